### design/fta_pkg.sv
`default_nettype none
package fta_pkg;

   // Tick counter and frame time widths
   localparam int unsigned STAMP_W  = 64;
   localparam int unsigned TICKS_W  = 32;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned ACCUM_W  = TICKS_W + 1;

   // Configuration register indexes
   localparam logic CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic CSR_MIN_FRAME_TICKS  = 1'b1;

   // Reset values of the configuration registers
   localparam logic [TICKS_W-1:0] TPS_RESET       = 32'd10000000;
   localparam logic [TICKS_W-1:0] MIN_TICKS_RESET = 32'd0;

   // Item kind carried in req_tuser
   localparam logic CMD_TICK    = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [RATE_W-1:0] RATE_MAX = '1;

   // Frame sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DIFF,
      S_CHECK,
      S_EVICT,
      S_ADD,
      S_RATE,
      S_DIV,
      S_FINISH
   } fta_state_type;

endpackage
`default_nettype wire

### design/fta_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module fta_div #(
   parameter int unsigned NUM_W = 38,
   parameter int unsigned DEN_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   rem_sh;
   logic             ge;
   logic [DEN_W:0]   rem_sub;

   // One shift-subtract step
   assign rem_sh  = {rem_ff, num_ff[NUM_W-1]};
   assign ge      = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   assign done = busy_ff && (cnt_ff == CNT_W'(1));
   assign quot = num_ff;

   // Control: count down the quotient bits
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath: shift the dividend out, the quotient bits in
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], ge};
         rem_ff <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      end
   end

endmodule
`default_nettype wire

### design/frame_time_averager.sv
`default_nettype none
// Frame time averager.
// req channel: one item per counter reading. req_tdata holds the 64-bit
// timestamp, req_tuser the command (0 tick, 1 restart). A restart only
// stores the reading. A tick measures the frame time; if the frame limiter
// (min_frame_ticks) has not yet passed, it is dropped with no result.
// rsp channel: one item per completed frame with the window average,
// the latched frame rate, the window fill and whether the frame time
// entered the window.
// A completed frame runs a bit-serial divide of the window sum by the fill
// count, one quotient bit per cycle; no divide runs while the window is
// empty. The next item is accepted after the result is loaded into the
// output register. Frame times live in a one-port synchronous memory, read
// in the cycle before its write-back. One item is in work at a time. A result
// waits in the output register while rsp_tready is low; the next item is
// still accepted, and its result waits for the register to drain.
// csr port: index 0 ticks_per_second, index 1 min_frame_ticks, written by the
// user only while idle; the block itself does not enforce it. Synchronous reset
// restores the sequencer, window counters, rate state, output valid and CSRs.
module frame_time_averager #(
   parameter int unsigned WINDOW_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: timestamp[63:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,
   // req_tuser: command[0]
   input  wire logic        req_tuser,
   // rsp_tdata: avg_frame_ticks[31:0], frame_rate[47:32],
   //            fill_count[FILL_W+47:48], sample_taken[FILL_W+48], zero pad
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [((49 + $clog2(WINDOW_DEPTH + 1) + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);

   import fta_pkg::*;

   localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned HEAD_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned SUM_W  = TICKS_W + $clog2(WINDOW_DEPTH);
   localparam int unsigned RSP_W  = ((49 + FILL_W + 7) / 8) * 8;

   fta_state_type state_ff, state_in;

   logic [TICKS_W-1:0] tps_ff;
   logic [TICKS_W-1:0] min_ticks_ff;

   logic [STAMP_W-1:0] stamp_ff;
   logic [STAMP_W-1:0] last_stamp_ff;
   logic [TICKS_W-1:0] elapsed_ff;
   logic               taken_ff;
   logic [HEAD_W-1:0]  head_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [TICKS_W-1:0] avg_ff;
   logic [RATE_W-1:0]  frames_ff;
   logic [ACCUM_W-1:0] accum_ff;
   logic [RATE_W-1:0]  rate_ff;

   logic [TICKS_W-1:0] window_mem [WINDOW_DEPTH];
   logic [TICKS_W-1:0] rd_data_ff;

   logic               rsp_valid_ff;
   logic [TICKS_W-1:0] rsp_avg_ff;
   logic [RATE_W-1:0]  rsp_rate_ff;
   logic [FILL_W-1:0]  rsp_fill_ff;
   logic               rsp_taken_ff;

   logic               req_fire;
   logic [STAMP_W-1:0] diff;
   logic               limit_pass;
   logic [TICKS_W-1:0] dev;
   logic               full;
   logic               rsp_load;
   logic               div_start;
   logic               div_done;
   logic [SUM_W-1:0]   div_quot;
   logic [TICKS_W-1:0] avg_in;

   assign req_fire   = req_tvalid && req_tready;
   assign diff       = stamp_ff - last_stamp_ff;
   assign limit_pass = (min_ticks_ff == '0) || (elapsed_ff >= min_ticks_ff);
   assign dev        = (elapsed_ff >= avg_ff) ? (elapsed_ff - avg_ff) : (avg_ff - elapsed_ff);
   assign full       = fill_ff == FILL_W'(WINDOW_DEPTH);
   assign avg_in     = (fill_ff != '0) ? div_quot[TICKS_W-1:0] : '0;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff       <= TPS_RESET;
         min_ticks_ff <= MIN_TICKS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TICKS_PER_SECOND: tps_ff       <= csr_wdata;
            CSR_MIN_FRAME_TICKS:  min_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and handshake outputs
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      div_start  = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid && (req_tuser == CMD_TICK)) begin
               state_in = S_DIFF;
            end
         end
         S_DIFF:  state_in = S_CHECK;
         S_CHECK: state_in = limit_pass ? S_EVICT : S_IDLE;
         S_EVICT: state_in = S_ADD;
         S_ADD:   state_in = S_RATE;
         S_RATE: begin
            if (fill_ff != '0) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Frame state update
   always_ff @(posedge clock) begin
      if (reset) begin
         last_stamp_ff <= '0;
         head_ff       <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         avg_ff        <= '0;
         frames_ff     <= '0;
         accum_ff      <= '0;
         rate_ff       <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_tuser == CMD_RESTART)) begin
                  last_stamp_ff <= req_tdata;
               end
            end
            S_CHECK: begin
               if (limit_pass) begin
                  last_stamp_ff <= stamp_ff;
               end
            end
            // Drop the oldest entry or grow the window
            S_EVICT: begin
               if (taken_ff) begin
                  if (full) begin
                     sum_ff <= sum_ff - SUM_W'(rd_data_ff);
                  end else begin
                     fill_ff <= fill_ff + FILL_W'(1);
                  end
                  head_ff <= (head_ff == HEAD_W'(WINDOW_DEPTH - 1)) ? '0
                                                                     : head_ff + HEAD_W'(1);
               end
            end
            S_ADD: begin
               if (taken_ff) begin
                  sum_ff <= sum_ff + SUM_W'(elapsed_ff);
               end
               if (frames_ff != RATE_MAX) begin
                  frames_ff <= frames_ff + RATE_W'(1);
               end
               accum_ff <= accum_ff + ACCUM_W'(elapsed_ff);
            end
            // Latch the rate once a second has gone by
            S_RATE: begin
               if (accum_ff > ACCUM_W'(tps_ff)) begin
                  rate_ff   <= frames_ff;
                  frames_ff <= '0;
                  accum_ff  <= '0;
               end
            end
            S_FINISH: begin
               if (rsp_load) begin
                  avg_ff <= avg_in;
               end
            end
            default: ;
         endcase
      end
   end

   // Per-item working registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stamp_ff <= req_tdata;
      end
      if (state_ff == S_DIFF) begin
         elapsed_ff <= (diff[STAMP_W-1:TICKS_W] != '0) ? '1 : diff[TICKS_W-1:0];
      end
      if (state_ff == S_CHECK) begin
         taken_ff <= dev < tps_ff;
      end
   end

   // Frame time memory: read at the head, write back the new frame time
   always_ff @(posedge clock) begin
      rd_data_ff <= window_mem[head_ff];
      if ((state_ff == S_EVICT) && taken_ff) begin
         window_mem[head_ff] <= elapsed_ff;
      end
   end

   fta_div #(
      .NUM_W(SUM_W),
      .DEN_W(FILL_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (sum_ff),
      .den  (fill_ff),
      .done (div_done),
      .quot (div_quot)
   );

   // Output register: hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_avg_ff   <= avg_in;
         rsp_rate_ff  <= rate_ff;
         rsp_fill_ff  <= fill_ff;
         rsp_taken_ff <= taken_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_taken_ff, rsp_fill_ff, rsp_rate_ff, rsp_avg_ff});

   // Window never holds more than its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_DEPTH))
      else $error("window fill above depth");

   // Until the window is full the head tracks the fill count
   a_head_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      !full |-> (FILL_W'(head_ff) == fill_ff))
      else $error("window head out of step with fill");

   // An empty window reports a zero average
   a_empty_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_load && (fill_ff == '0) |=> (rsp_avg_ff == '0))
      else $error("nonzero average from empty window");

   // A taken frame time leaves a nonempty window
   a_taken_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_taken_ff |-> (rsp_fill_ff != '0))
      else $error("frame taken but window empty");

endmodule
`default_nettype wire

### dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fta_pkg::*;

   localparam int unsigned DEPTH         = 64;
   localparam int unsigned HEAD_W        = $clog2(DEPTH);
   localparam int unsigned FILL_W        = $clog2(DEPTH + 1);
   localparam int unsigned SUM_W         = TICKS_W + HEAD_W;
   localparam int unsigned RSP_W         = ((49 + FILL_W + 7) / 8) * 8;
   localparam int unsigned SETTLE_CYCLES = 60;
   localparam int unsigned DRAIN_LIMIT   = 20000;

   typedef struct packed {
      logic [TICKS_W-1:0] avg_ticks;
      logic [RATE_W-1:0]  rate;
      logic [FILL_W-1:0]  fill;
      logic               taken;
   } frame_result_type;

   typedef enum logic [1:0] {ROW_TICK, ROW_RESTART, ROW_SET_TPS, ROW_SET_MIN} row_kind_type;

   typedef struct {
      row_kind_type       kind;
      logic [STAMP_W-1:0] value;
      bit                 known;
      frame_result_type   result;
   } stim_row_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_pattern_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [STAMP_W-1:0] req_tdata  = '0;
   logic               req_tuser  = CMD_TICK;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_we     = 1'b0;
   logic               csr_index  = CSR_TICKS_PER_SECOND;
   logic [TICKS_W-1:0] csr_wdata  = '0;

   // Frame timer state as the block should hold it
   logic [TICKS_W-1:0] tps_setting    = TPS_RESET;
   logic [TICKS_W-1:0] min_setting    = MIN_TICKS_RESET;
   logic [STAMP_W-1:0] stamp_mark     = '0;
   logic [TICKS_W-1:0] window_mem [DEPTH];
   logic [HEAD_W-1:0]  window_head    = '0;
   logic [FILL_W-1:0]  window_fill    = '0;
   logic [SUM_W-1:0]   window_sum     = '0;
   logic [TICKS_W-1:0] frame_avg      = '0;
   logic [RATE_W-1:0]  frames_counted = '0;
   logic [ACCUM_W-1:0] second_ticks   = '0;
   logic [RATE_W-1:0]  rate_latched   = '0;

   frame_result_type   pending_frames [$];
   stim_row_type       directed_rows [$];
   logic [STAMP_W-1:0] stamp_now     = '0;
   bit                 steady_sender = 1'b0;
   int                 burst_left    = 0;
   int                 mismatches    = 0;
   int                 frames_seen   = 0;
   ready_pattern_type  ready_pattern = READY_ALWAYS;
   int                 pattern_left  = 0;

   frame_time_averager #(.WINDOW_DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Advance the frame timer by one item; return 1 when a frame completes
   function automatic bit measure_frame(input logic cmd, input logic [STAMP_W-1:0] stamp,
                                        output frame_result_type res);
      logic [STAMP_W-1:0] span;
      logic [TICKS_W-1:0] elapsed;
      logic [TICKS_W-1:0] deviation;
      res = '0;
      if (cmd == CMD_RESTART) begin
         stamp_mark = stamp;
         return 1'b0;
      end
      span    = stamp - stamp_mark;
      elapsed = (span > 64'hFFFF_FFFF) ? '1 : span[TICKS_W-1:0];
      // drop the tick while the frame limiter has not yet passed
      if (min_setting != '0 && elapsed < min_setting) begin
         return 1'b0;
      end
      stamp_mark = stamp;
      // take the frame time only when it lies within one second of the average
      deviation = (elapsed >= frame_avg) ? elapsed - frame_avg : frame_avg - elapsed;
      if (deviation < tps_setting) begin
         if (window_fill == FILL_W'(DEPTH)) begin
            window_sum -= window_mem[window_head];
         end else begin
            window_fill++;
         end
         window_mem[window_head] = elapsed;
         window_sum += elapsed;
         window_head++;
         res.taken = 1'b1;
      end
      // count frames and latch the rate once a second has gone by
      if (frames_counted != RATE_MAX) begin
         frames_counted++;
      end
      second_ticks += elapsed;
      if (second_ticks > tps_setting) begin
         rate_latched   = frames_counted;
         frames_counted = '0;
         second_ticks   = '0;
      end
      frame_avg     = (window_fill != '0) ? TICKS_W'(window_sum / window_fill) : '0;
      res.avg_ticks = frame_avg;
      res.rate      = rate_latched;
      res.fill      = window_fill;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("frame %0d %s: got 0x%0h, expected 0x%0h", frames_seen, what, got, want);
      mismatches++;
   endtask

   function automatic void add_row(input row_kind_type kind, input logic [STAMP_W-1:0] value,
                                   input bit known = 1'b0,
                                   input frame_result_type result = '0);
      directed_rows.push_back('{kind, value, known, result});
   endfunction

   // Send one item, after a random gap at the start of a burst, then queue its frame
   task automatic send_item(input logic cmd, input logic [STAMP_W-1:0] stamp,
                            input bit known, input frame_result_type known_result);
      frame_result_type predicted;
      int gap;
      if (burst_left == 0) begin
         if (steady_sender) begin
            gap = 0;
         end else if ($urandom_range(0, 4) == 0) begin
            gap = $urandom_range(13, 60);
         end else begin
            gap = $urandom_range(0, 12);
         end
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
      stamp_now = stamp;
      if (measure_frame(cmd, stamp, predicted)) begin
         pending_frames.push_back(known ? known_result : predicted);
      end
   endtask

   // Hold the sender until every pending frame has come out or the drain limit runs out
   task automatic wait_for_results();
      int n;
      req_tvalid <= 1'b0;
      n = 0;
      do begin
         @(posedge clock);
         n++;
      end while (pending_frames.size() != 0 && n < DRAIN_LIMIT);
   endtask

   task automatic write_register(input logic index, input logic [TICKS_W-1:0] value);
      wait_for_results();
      // let a dropped tick finish before touching the registers
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_TICKS_PER_SECOND) begin
         tps_setting = value;
      end else begin
         min_setting = value;
      end
   endtask

   // Mostly steady frames around a base period, mixed with outliers and noise
   task automatic run_phase(input logic [TICKS_W-1:0] tps, input logic [TICKS_W-1:0] min_ticks,
                            input logic [STAMP_W-1:0] base, input logic [TICKS_W-1:0] spread,
                            input int count, input bit steady);
      int pick;
      logic cmd;
      logic [STAMP_W-1:0] stamp;
      write_register(CSR_TICKS_PER_SECOND, tps);
      write_register(CSR_MIN_FRAME_TICKS, min_ticks);
      steady_sender = steady;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) begin
            wait_for_results();
         end
         pick = $urandom_range(0, 99);
         cmd  = CMD_TICK;
         if (pick < 70) begin
            stamp = stamp_now + base + $urandom_range(0, spread);
         end else if (pick < 80) begin
            stamp = stamp_now + $urandom_range(0, (min_ticks == 0) ? 3 : min_ticks);
         end else if (pick < 88) begin
            stamp = stamp_now + {$urandom, $urandom};
         end else if (pick < 95) begin
            cmd   = CMD_RESTART;
            stamp = {$urandom, $urandom};
         end else begin
            stamp = {$urandom, $urandom};
         end
         send_item(cmd, stamp, 1'b0, '0);
      end
   endtask

   task automatic check_frame(input logic [RSP_W-1:0] data);
      frame_result_type want;
      frame_result_type got;
      got.avg_ticks = data[31:0];
      got.rate      = data[47:32];
      got.fill      = data[48 +: FILL_W];
      got.taken     = data[48 + FILL_W];
      if (pending_frames.size() == 0) begin
         report_mismatch("unexpected result", 64'(data), '0);
      end else begin
         want = pending_frames.pop_front();
         if (got.avg_ticks !== want.avg_ticks) begin
            report_mismatch("avg_frame_ticks", 64'(got.avg_ticks), 64'(want.avg_ticks));
         end
         if (got.rate !== want.rate) begin
            report_mismatch("frame_rate", 64'(got.rate), 64'(want.rate));
         end
         if (got.fill !== want.fill) begin
            report_mismatch("fill_count", 64'(got.fill), 64'(want.fill));
         end
         if (got.taken !== want.taken) begin
            report_mismatch("sample_taken", 64'(got.taken), 64'(want.taken));
         end
      end
      frames_seen++;
   endtask

   // Check each result item and stall on a changing pattern
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         check_frame(rsp_tdata);
      end
      if (pattern_left == 0) begin
         ready_pattern = ready_pattern_type'($urandom_range(0, 3));
         pattern_left  = $urandom_range(50, 400);
      end else begin
         pattern_left--;
      end
      case (ready_pattern)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         READY_SPARSE: begin
            rsp_tready <= ($urandom_range(0, 7) == 0);
         end
         default: begin
            rsp_tready <= (pattern_left % 32) >= 24;
         end
      endcase
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // first frames after reset, counter wrap and saturated frame times
      add_row(ROW_TICK, 64'd100, 1'b1, '{32'd100, 16'd0, 7'd1, 1'b1});
      add_row(ROW_TICK, 64'd300, 1'b1, '{32'd150, 16'd0, 7'd2, 1'b1});
      add_row(ROW_RESTART, 64'hFFFF_FFFF_FFFF_FF00);
      add_row(ROW_TICK, 64'h0000_0000_0000_0032, 1'b1, '{32'd202, 16'd0, 7'd3, 1'b1});
      add_row(ROW_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{32'd202, 16'd4, 7'd3, 1'b0});
      add_row(ROW_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{32'd151, 16'd4, 7'd4, 1'b1});
      add_row(ROW_RESTART, 64'h0);
      add_row(ROW_TICK, 64'h0000_0001_0000_0000, 1'b1, '{32'd151, 16'd2, 7'd4, 1'b0});
      add_row(ROW_TICK, 64'h0000_0001_FFFF_FFFF, 1'b1, '{32'd151, 16'd1, 7'd4, 1'b0});
      // frame limiter: one tick short of the period, then exactly on it
      add_row(ROW_SET_MIN, 64'd1000);
      add_row(ROW_TICK, 64'h0000_0002_0000_03E6);
      add_row(ROW_TICK, 64'h0000_0002_0000_03E7, 1'b1, '{32'd321, 16'd1, 7'd5, 1'b1});
      // zero second: nothing taken, rate latches at once
      add_row(ROW_SET_TPS, 64'd0);
      add_row(ROW_TICK, 64'h0000_0002_0000_07CF, 1'b1, '{32'd321, 16'd2, 7'd5, 1'b0});
      // widest second: accumulated time equal to it must not latch
      add_row(ROW_SET_TPS, 64'hFFFF_FFFF);
      add_row(ROW_SET_MIN, 64'd0);
      add_row(ROW_TICK, 64'h0000_0002_0000_07CF, 1'b1, '{32'd267, 16'd2, 7'd6, 1'b1});
      add_row(ROW_TICK, 64'h0000_0003_0000_07CE, 1'b1, '{32'd613566985, 16'd2, 7'd7, 1'b1});
      add_row(ROW_TICK, 64'h0000_0003_0000_07CF, 1'b1, '{32'd536871112, 16'd3, 7'd8, 1'b1});

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_TICK: begin
               send_item(CMD_TICK, directed_rows[r].value, directed_rows[r].known,
                         directed_rows[r].result);
            end
            ROW_RESTART: begin
               send_item(CMD_RESTART, directed_rows[r].value, 1'b0, '0);
            end
            ROW_SET_TPS: begin
               write_register(CSR_TICKS_PER_SECOND, directed_rows[r].value[TICKS_W-1:0]);
            end
            default: begin
               write_register(CSR_MIN_FRAME_TICKS, directed_rows[r].value[TICKS_W-1:0]);
            end
         endcase
      end

      // random phases across register settings, extremes included
      run_phase(32'd10000000, 32'd0, 64'd100000, 32'd40000, 165, 1'b0);
      run_phase(32'd1000, 32'd0, 64'd100, 32'd1500, 165, 1'b0);
      run_phase(32'd50000, 32'd300, 64'd300, 32'd400, 165, 1'b1);
      run_phase(32'd0, 32'd1, 64'd0, 32'd20, 165, 1'b0);
      run_phase(32'd1, 32'd0, 64'd7, 32'd1, 165, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF, 32'd1000, 165, 1'b0);
      run_phase(32'hFFFF_FFFF, 32'd0, 64'hF000_0000, 32'h0FFF_FFFF, 165, 1'b1);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_frames.size() != 0) begin
         report_mismatch("results never delivered", 64'(pending_frames.size()), '0);
      end
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #10ms;
      $display("TEST FAILED");
      $finish;
   end

endmodule

### sim.f
design/fta_pkg.sv
design/fta_div.sv
design/frame_time_averager.sv
dv/testbench.sv
